FILE: rtl/tvaq_pkg.sv
// ----------------------------------------------------------------------------
// tvaq_pkg
// Types, constants and the microcode program of the two-vector attitude
// quaternion core.
// ----------------------------------------------------------------------------
package tvaq_pkg;

  localparam int DATA_W    = 32;
  localparam int MEM_DEPTH = 64;
  localparam int MEM_AW    = 6;
  localparam int PC_W      = 7;

  localparam logic [3:0]  SLOT_NONE  = 4'd15;
  localparam logic [31:0] Q16_ONE    = 32'h0001_0000;
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN    = 32'h8000_0000;
  localparam logic [15:0] THR_RESET  = 16'd2048;
  localparam logic [16:0] MW_RESET   = 17'd32768;
  localparam logic [16:0] MW_FULL    = 17'd65536;

  // configuration register indexes
  localparam logic [0:0] CFG_DARK_THR = 1'b0;
  localparam logic [0:0] CFG_MAG_W    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_RDA, ST_RDB, ST_ACC, ST_SQRT, ST_DIV, ST_EMIT
  } st_t;

  typedef enum logic [3:0] {
    OP_SUN, OP_DARK, OP_MAC, OP_SQ, OP_ROOT, OP_NDIV,
    OP_BR, OP_JMP, OP_ARG, OP_ODIV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [MEM_AW-1:0]  a;
    logic [MEM_AW-1:0]  b;
    logic [MEM_AW-1:0]  d;
    logic               clr;
    logic               neg;
    logic               wr;
    logic [PC_W-1:0]    tgt;
  } uins_t;

  // scratch memory map
  localparam logic [5:0] A_B1  = 6'd6;
  localparam logic [5:0] A_R1  = 6'd9;
  localparam logic [5:0] A_R2  = 6'd12;
  localparam logic [5:0] A_B2  = 6'd16;
  localparam logic [5:0] A_B3  = 6'd20;
  localparam logic [5:0] A_R3  = 6'd24;
  localparam logic [5:0] A_T1  = 6'd28;
  localparam logic [5:0] A_T2  = 6'd32;
  localparam logic [5:0] A_MC  = 6'd36;
  localparam logic [5:0] A_MA  = 6'd40;
  localparam logic [5:0] A_C   = 6'd44;
  localparam logic [5:0] A_MU  = 6'd45;
  localparam logic [5:0] A_NU  = 6'd46;
  localparam logic [5:0] A_RHO = 6'd47;
  localparam logic [5:0] A_A   = 6'd48;
  localparam logic [5:0] A_ARG = 6'd49;
  localparam logic [5:0] A_X0  = 6'd50;
  localparam logic [5:0] A_X1  = 6'd51;
  localparam logic [5:0] A_P   = 6'd52;
  localparam logic [5:0] A_WT  = 6'd56;
  localparam logic [5:0] A_ONE = 6'd60;
  localparam logic [5:0] A_W   = 6'd61;
  localparam logic [5:0] A_WC  = 6'd62;

  localparam logic [2:0] F_NONE = 3'b000;
  localparam logic [2:0] F_CLR  = 3'b100;
  localparam logic [2:0] F_NEG  = 3'b010;
  localparam logic [2:0] F_WR   = 3'b001;

  localparam logic [PC_W-1:0] PC_ELSE = 7'd103;
  localparam logic [PC_W-1:0] PC_JOIN = 7'd112;
  localparam logic [PC_W-1:0] PC_NONE = 7'd0;

  function automatic uins_t ui(input op_t op, input logic [5:0] a, input logic [5:0] b,
                               input logic [5:0] d, input logic [2:0] f,
                               input logic [PC_W-1:0] tgt);
    uins_t r;
    r.op  = op;
    r.a   = a;
    r.b   = b;
    r.d   = d;
    r.clr = f[2];
    r.neg = f[1];
    r.wr  = f[0];
    r.tgt = tgt;
    return r;
  endfunction

  function automatic uins_t mac(input logic [5:0] a, input logic [5:0] b,
                                input logic [2:0] f, input logic [5:0] d);
    return ui(OP_MAC, a, b, d, f, PC_NONE);
  endfunction

  function automatic uins_t sq(input logic [5:0] a, input logic [2:0] f);
    return ui(OP_SQ, a, a, a, f, PC_NONE);
  endfunction

  function automatic uins_t one(input op_t op, input logic [5:0] a, input logic [5:0] d);
    return ui(op, a, a, d, F_NONE, PC_NONE);
  endfunction

  function automatic uins_t prog(input logic [PC_W-1:0] pc);
    uins_t r;
    unique case (pc)
      // sun axes and dark check
      7'd0:   r = ui(OP_SUN, 6'd0, 6'd1, A_B2, F_NONE, PC_NONE);
      7'd1:   r = ui(OP_SUN, 6'd2, 6'd3, A_B2 + 6'd1, F_NONE, PC_NONE);
      7'd2:   r = ui(OP_SUN, 6'd4, 6'd5, A_B2 + 6'd2, F_NONE, PC_NONE);
      7'd3:   r = one(OP_DARK, A_B2, A_B2);
      // normalize b2
      7'd4:   r = sq(A_B2, F_CLR);
      7'd5:   r = sq(A_B2 + 6'd1, F_NONE);
      7'd6:   r = sq(A_B2 + 6'd2, F_NONE);
      7'd7:   r = one(OP_ROOT, A_B2, A_B2);
      7'd8:   r = one(OP_NDIV, A_B2, A_B2);
      7'd9:   r = one(OP_NDIV, A_B2 + 6'd1, A_B2 + 6'd1);
      7'd10:  r = one(OP_NDIV, A_B2 + 6'd2, A_B2 + 6'd2);
      // b3 = b1 x b2, then normalize b3
      7'd11:  r = mac(A_B1 + 6'd1, A_B2 + 6'd2, F_CLR, A_B3);
      7'd12:  r = mac(A_B1 + 6'd2, A_B2 + 6'd1, F_NEG | F_WR, A_B3);
      7'd13:  r = mac(A_B1 + 6'd2, A_B2, F_CLR, A_B3);
      7'd14:  r = mac(A_B1, A_B2 + 6'd2, F_NEG | F_WR, A_B3 + 6'd1);
      7'd15:  r = mac(A_B1, A_B2 + 6'd1, F_CLR, A_B3);
      7'd16:  r = mac(A_B1 + 6'd1, A_B2, F_NEG | F_WR, A_B3 + 6'd2);
      7'd17:  r = sq(A_B3, F_CLR);
      7'd18:  r = sq(A_B3 + 6'd1, F_NONE);
      7'd19:  r = sq(A_B3 + 6'd2, F_NONE);
      7'd20:  r = one(OP_ROOT, A_B3, A_B3);
      7'd21:  r = one(OP_NDIV, A_B3, A_B3);
      7'd22:  r = one(OP_NDIV, A_B3 + 6'd1, A_B3 + 6'd1);
      7'd23:  r = one(OP_NDIV, A_B3 + 6'd2, A_B3 + 6'd2);
      // r3 = r1 x r2, then normalize r3
      7'd24:  r = mac(A_R1 + 6'd1, A_R2 + 6'd2, F_CLR, A_R3);
      7'd25:  r = mac(A_R1 + 6'd2, A_R2 + 6'd1, F_NEG | F_WR, A_R3);
      7'd26:  r = mac(A_R1 + 6'd2, A_R2, F_CLR, A_R3);
      7'd27:  r = mac(A_R1, A_R2 + 6'd2, F_NEG | F_WR, A_R3 + 6'd1);
      7'd28:  r = mac(A_R1, A_R2 + 6'd1, F_CLR, A_R3);
      7'd29:  r = mac(A_R1 + 6'd1, A_R2, F_NEG | F_WR, A_R3 + 6'd2);
      7'd30:  r = sq(A_R3, F_CLR);
      7'd31:  r = sq(A_R3 + 6'd1, F_NONE);
      7'd32:  r = sq(A_R3 + 6'd2, F_NONE);
      7'd33:  r = one(OP_ROOT, A_R3, A_R3);
      7'd34:  r = one(OP_NDIV, A_R3, A_R3);
      7'd35:  r = one(OP_NDIV, A_R3 + 6'd1, A_R3 + 6'd1);
      7'd36:  r = one(OP_NDIV, A_R3 + 6'd2, A_R3 + 6'd2);
      // c = 1 + b3.r3
      7'd37:  r = mac(A_B3, A_R3, F_CLR, A_X0);
      7'd38:  r = mac(A_B3 + 6'd1, A_R3 + 6'd1, F_NONE, A_X0);
      7'd39:  r = mac(A_B3 + 6'd2, A_R3 + 6'd2, F_WR, A_X0);
      7'd40:  r = mac(A_ONE, A_ONE, F_CLR, A_C);
      7'd41:  r = mac(A_X0, A_ONE, F_WR, A_C);
      // mu = c * weigh(b1.r1, b2.r2)
      7'd42:  r = mac(A_B1, A_R1, F_CLR, A_X0);
      7'd43:  r = mac(A_B1 + 6'd1, A_R1 + 6'd1, F_NONE, A_X0);
      7'd44:  r = mac(A_B1 + 6'd2, A_R1 + 6'd2, F_WR, A_X0);
      7'd45:  r = mac(A_B2, A_R2, F_CLR, A_X1);
      7'd46:  r = mac(A_B2 + 6'd1, A_R2 + 6'd1, F_NONE, A_X1);
      7'd47:  r = mac(A_B2 + 6'd2, A_R2 + 6'd2, F_WR, A_X1);
      7'd48:  r = mac(A_X0, A_W, F_CLR, A_WT);
      7'd49:  r = mac(A_X1, A_WC, F_WR, A_WT);
      7'd50:  r = mac(A_C, A_WT, F_CLR | F_WR, A_MU);
      // t1 = b1 x r1
      7'd51:  r = mac(A_B1 + 6'd1, A_R1 + 6'd2, F_CLR, A_T1);
      7'd52:  r = mac(A_B1 + 6'd2, A_R1 + 6'd1, F_NEG | F_WR, A_T1);
      7'd53:  r = mac(A_B1 + 6'd2, A_R1, F_CLR, A_T1);
      7'd54:  r = mac(A_B1, A_R1 + 6'd2, F_NEG | F_WR, A_T1 + 6'd1);
      7'd55:  r = mac(A_B1, A_R1 + 6'd1, F_CLR, A_T1);
      7'd56:  r = mac(A_B1 + 6'd1, A_R1, F_NEG | F_WR, A_T1 + 6'd2);
      // t2 = b2 x r2
      7'd57:  r = mac(A_B2 + 6'd1, A_R2 + 6'd2, F_CLR, A_T2);
      7'd58:  r = mac(A_B2 + 6'd2, A_R2 + 6'd1, F_NEG | F_WR, A_T2);
      7'd59:  r = mac(A_B2 + 6'd2, A_R2, F_CLR, A_T2);
      7'd60:  r = mac(A_B2, A_R2 + 6'd2, F_NEG | F_WR, A_T2 + 6'd1);
      7'd61:  r = mac(A_B2, A_R2 + 6'd1, F_CLR, A_T2);
      7'd62:  r = mac(A_B2 + 6'd1, A_R2, F_NEG | F_WR, A_T2 + 6'd2);
      // t2 = weigh(t1, t2)
      7'd63:  r = mac(A_T1, A_W, F_CLR, A_T2);
      7'd64:  r = mac(A_T2, A_WC, F_WR, A_T2);
      7'd65:  r = mac(A_T1 + 6'd1, A_W, F_CLR, A_T2);
      7'd66:  r = mac(A_T2 + 6'd1, A_WC, F_WR, A_T2 + 6'd1);
      7'd67:  r = mac(A_T1 + 6'd2, A_W, F_CLR, A_T2);
      7'd68:  r = mac(A_T2 + 6'd2, A_WC, F_WR, A_T2 + 6'd2);
      // mc = b3 x r3
      7'd69:  r = mac(A_B3 + 6'd1, A_R3 + 6'd2, F_CLR, A_MC);
      7'd70:  r = mac(A_B3 + 6'd2, A_R3 + 6'd1, F_NEG | F_WR, A_MC);
      7'd71:  r = mac(A_B3 + 6'd2, A_R3, F_CLR, A_MC);
      7'd72:  r = mac(A_B3, A_R3 + 6'd2, F_NEG | F_WR, A_MC + 6'd1);
      7'd73:  r = mac(A_B3, A_R3 + 6'd1, F_CLR, A_MC);
      7'd74:  r = mac(A_B3 + 6'd1, A_R3, F_NEG | F_WR, A_MC + 6'd2);
      // mu += mc.t2
      7'd75:  r = mac(A_MC, A_T2, F_CLR, A_X0);
      7'd76:  r = mac(A_MC + 6'd1, A_T2 + 6'd1, F_NONE, A_X0);
      7'd77:  r = mac(A_MC + 6'd2, A_T2 + 6'd2, F_WR, A_X0);
      7'd78:  r = mac(A_MU, A_ONE, F_CLR, A_MU);
      7'd79:  r = mac(A_X0, A_ONE, F_WR, A_MU);
      // ma = b3 + r3
      7'd80:  r = mac(A_B3, A_ONE, F_CLR, A_MA);
      7'd81:  r = mac(A_R3, A_ONE, F_WR, A_MA);
      7'd82:  r = mac(A_B3 + 6'd1, A_ONE, F_CLR, A_MA);
      7'd83:  r = mac(A_R3 + 6'd1, A_ONE, F_WR, A_MA + 6'd1);
      7'd84:  r = mac(A_B3 + 6'd2, A_ONE, F_CLR, A_MA);
      7'd85:  r = mac(A_R3 + 6'd2, A_ONE, F_WR, A_MA + 6'd2);
      // nu = ma.t2
      7'd86:  r = mac(A_MA, A_T2, F_CLR, A_NU);
      7'd87:  r = mac(A_MA + 6'd1, A_T2 + 6'd1, F_NONE, A_NU);
      7'd88:  r = mac(A_MA + 6'd2, A_T2 + 6'd2, F_WR, A_NU);
      // rho = sqrt(mu^2 + nu^2)
      7'd89:  r = sq(A_MU, F_CLR);
      7'd90:  r = sq(A_NU, F_NONE);
      7'd91:  r = ui(OP_ROOT, A_RHO, A_RHO, A_RHO, F_WR, PC_NONE);
      7'd92:  r = ui(OP_BR, A_MU, A_MU, A_MU, F_NONE, PC_ELSE);
      // mu positive
      7'd93:  r = mac(A_RHO, A_ONE, F_CLR, A_A);
      7'd94:  r = mac(A_MU, A_ONE, F_WR, A_A);
      7'd95:  r = mac(A_MC, A_A, F_CLR, A_P);
      7'd96:  r = mac(A_MA, A_NU, F_WR, A_P);
      7'd97:  r = mac(A_MC + 6'd1, A_A, F_CLR, A_P);
      7'd98:  r = mac(A_MA + 6'd1, A_NU, F_WR, A_P + 6'd1);
      7'd99:  r = mac(A_MC + 6'd2, A_A, F_CLR, A_P);
      7'd100: r = mac(A_MA + 6'd2, A_NU, F_WR, A_P + 6'd2);
      7'd101: r = mac(A_A, A_C, F_CLR | F_WR, A_P + 6'd3);
      7'd102: r = ui(OP_JMP, A_A, A_A, A_A, F_NONE, PC_JOIN);
      // mu not positive
      7'd103: r = mac(A_RHO, A_ONE, F_CLR, A_A);
      7'd104: r = mac(A_MU, A_ONE, F_NEG | F_WR, A_A);
      7'd105: r = mac(A_MC, A_NU, F_CLR, A_P);
      7'd106: r = mac(A_MA, A_A, F_WR, A_P);
      7'd107: r = mac(A_MC + 6'd1, A_NU, F_CLR, A_P);
      7'd108: r = mac(A_MA + 6'd1, A_A, F_WR, A_P + 6'd1);
      7'd109: r = mac(A_MC + 6'd2, A_NU, F_CLR, A_P);
      7'd110: r = mac(A_MA + 6'd2, A_A, F_WR, A_P + 6'd2);
      7'd111: r = mac(A_NU, A_C, F_CLR | F_WR, A_P + 6'd3);
      // arg = (rho * a) * c, then scale
      7'd112: r = mac(A_RHO, A_A, F_CLR | F_WR, A_ARG);
      7'd113: r = mac(A_ARG, A_C, F_CLR | F_WR, A_ARG);
      7'd114: r = one(OP_ARG, A_ARG, A_ARG);
      7'd115: r = one(OP_ROOT, A_ARG, A_ARG);
      7'd116: r = one(OP_ODIV, A_P, 6'd0);
      7'd117: r = one(OP_ODIV, A_P + 6'd1, 6'd1);
      7'd118: r = one(OP_ODIV, A_P + 6'd2, 6'd2);
      7'd119: r = one(OP_ODIV, A_P + 6'd3, 6'd3);
      default: r = one(OP_EMIT, A_P, A_P);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = SAT_MAX;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = SAT_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/tvaq_ram.sv
// ----------------------------------------------------------------------------
// tvaq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tvaq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/two_vector_attitude_quaternion_core.sv
// ----------------------------------------------------------------------------
// two_vector_attitude_quaternion_core
// Optimal attitude quaternion from a measured sun and magnetic vector pair,
// run as microcode over one multiplier, a radix-2 root unit and a radix-2
// divider sharing one scratch RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | sink      | tvalid / tready   | tuser {slot, cmd}, tdata value
//  out_    | source    | tvalid / tready   | tuser {error, light}, tdata quat
//  cfg_    | sink      | cfg_we            | cfg_addr, cfg_wdata
//
// a load word is written to its scratch slot as it is accepted. a lit compute
// word runs its multiply-accumulate steps, square roots and up to 13
// divisions one after another, one quotient bit per cycle in the shared divider.
// all sensors dark ends the compute early, as does a non-positive root
// argument, and a zero vector's normalizing steps skip the divider.
// in_tready stays low while a compute runs; the output register holds one
// result, so loads go on while it waits. the scratch RAM needs no clearing.
// ----------------------------------------------------------------------------
module two_vector_attitude_quaternion_core
  import tvaq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // value[31:0]
  input  logic [4:0]    in_tuser,   // cmd[0], slot[4:1]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // quat_x[31:0], quat_y, quat_z, quat_s[127:96]
  output logic [1:0]    out_tuser,  // light[0], error[1]
  input  logic          cfg_we,
  input  logic [0:0]    cfg_addr,
  input  logic [16:0]   cfg_wdata
);

  st_t                state_r, state_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  uins_t              ins;
  logic [63:0]        acc_r, acc_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [31:0]        opa_r, opa_nxt;
  logic [31:0]        root_r, root_nxt;
  logic [63:0]        rad_r, rad_nxt;
  logic [35:0]        srem_r, srem_nxt;
  logic [4:0]         scnt_r, scnt_nxt;
  logic [63:0]        dq_r, dq_nxt;
  logic [32:0]        drem_r, drem_nxt;
  logic [32:0]        dvs_r, dvs_nxt;
  logic [5:0]         dcnt_r, dcnt_nxt;
  logic               dneg_r, dneg_nxt;
  logic               lit_r, lit_nxt;
  logic [15:0]        thr_r;
  logic [16:0]        mw_r;
  logic               res_light_r, res_light_nxt;
  logic               res_err_r, res_err_nxt;
  logic [3:0][31:0]   res_q_r, res_q_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_light_r, out_light_nxt;
  logic               out_err_r, out_err_nxt;
  logic [3:0][31:0]   out_q_r, out_q_nxt;

  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0]  mem_wdata, mem_rdata;

  logic [16:0]        w_eff, w_cmp;
  logic [31:0]        opb, mul_b;
  logic signed [63:0] mul_res;
  logic signed [63:0] term, acc_base, acc_sum;
  logic [35:0]        s_sh, s_trial;
  logic [31:0]        root_step;
  logic [35:0]        srem_step;
  logic [33:0]        d_sh;
  logic [63:0]        dq_step;
  logic [32:0]        drem_step;
  logic [63:0]        dq_signed;
  logic [31:0]        opa_mag;
  logic [15:0]        sun_p, sun_m;
  logic [31:0]        sun_axis;
  logic [31:0]        div_sat;

  localparam logic [3:0][31:0] IDENT = {Q30_ONE, 32'd0, 32'd0, 32'd0};

  tvaq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [31:0] opnd(input logic [5:0] addr, input logic [31:0] data,
                                       input logic [16:0] w, input logic [16:0] wc);
    logic [31:0] r;
    if (addr == A_ONE) begin
      r = Q16_ONE;
    end else if (addr == A_W) begin
      r = {15'd0, w};
    end else if (addr == A_WC) begin
      r = {15'd0, wc};
    end else begin
      r = data;
    end
    return r;
  endfunction

  assign ins   = prog(pc_r);
  assign w_eff = (mw_r > MW_FULL) ? MW_FULL : mw_r;
  assign w_cmp = MW_FULL - w_eff;
  assign opb   = opnd(ins.b, mem_rdata, w_eff, w_cmp);
  assign mul_b = (ins.op == OP_SQ) ? opa_r : opb;
  assign mul_res = $signed(opa_r) * $signed(mul_b);

  // accumulate: squares stay raw, products drop 16 fraction bits with floor
  assign term     = (ins.op == OP_SQ) ? prod_r : (prod_r >>> 16);
  assign acc_base = ins.clr ? 64'sd0 : $signed(acc_r);
  assign acc_sum  = ins.neg ? (acc_base - term) : (acc_base + term);

  // root unit, two radicand bits per cycle
  assign s_sh    = {srem_r[33:0], rad_r[63:62]};
  assign s_trial = {2'b00, root_r, 2'b01};
  always_comb begin
    if (s_sh >= s_trial) begin
      srem_step = s_sh - s_trial;
      root_step = {root_r[30:0], 1'b1};
    end else begin
      srem_step = s_sh;
      root_step = {root_r[30:0], 1'b0};
    end
  end

  // divider, one quotient bit per cycle
  assign d_sh = {drem_r, dq_r[63]};
  always_comb begin
    if (d_sh >= {1'b0, dvs_r}) begin
      drem_step = 33'(d_sh - {1'b0, dvs_r});
      dq_step   = {dq_r[62:0], 1'b1};
    end else begin
      drem_step = d_sh[32:0];
      dq_step   = {dq_r[62:0], 1'b0};
    end
  end
  assign dq_signed = dneg_r ? (64'd0 - dq_step) : dq_step;

  always_comb begin
    if (!dneg_r) begin
      div_sat = (dq_step[63:31] != '0) ? SAT_MAX : dq_step[31:0];
    end else if ((dq_step[63:32] != '0) || (dq_step[31] && (dq_step[30:0] != '0))) begin
      div_sat = SAT_MIN;
    end else begin
      div_sat = dq_signed[31:0];
    end
  end

  assign opa_mag  = opa_r[31] ? (32'd0 - opa_r) : opa_r;
  assign sun_p    = opa_r[15:0];
  assign sun_m    = opb[15:0];
  assign sun_axis = (sun_p > sun_m) ? {16'd0, sun_p} : (32'd0 - {16'd0, sun_m});

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    opa_nxt       = opa_r;
    root_nxt      = root_r;
    rad_nxt       = rad_r;
    srem_nxt      = srem_r;
    scnt_nxt      = scnt_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;
    dneg_nxt      = dneg_r;
    lit_nxt       = lit_r;
    res_light_nxt = res_light_r;
    res_err_nxt   = res_err_r;
    res_q_nxt     = res_q_r;
    out_valid_nxt = out_valid_r;
    out_light_nxt = out_light_r;
    out_err_nxt   = out_err_r;
    out_q_nxt     = out_q_r;
    mem_we        = 1'b0;
    mem_waddr     = ins.d;
    mem_wdata     = '0;
    mem_raddr     = ins.a;
    in_tready     = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            lit_nxt   = 1'b0;
            pc_nxt    = '0;
            state_nxt = ST_ISSUE;
          end else if (in_tuser[4:1] != SLOT_NONE) begin
            mem_we    = 1'b1;
            mem_waddr = {2'b00, in_tuser[4:1]};
            mem_wdata = in_tdata;
          end
        end
      end
      ST_ISSUE: begin
        unique case (ins.op)
          OP_DARK: begin
            if (!lit_r) begin
              res_light_nxt = 1'b0;
              res_err_nxt   = 1'b0;
              res_q_nxt     = IDENT;
              state_nxt     = ST_EMIT;
            end else begin
              pc_nxt = pc_r + 7'd1;
            end
          end
          OP_ROOT: begin
            root_nxt  = '0;
            srem_nxt  = '0;
            rad_nxt   = acc_r;
            scnt_nxt  = '0;
            state_nxt = ST_SQRT;
          end
          OP_JMP: begin
            pc_nxt = ins.tgt;
          end
          OP_EMIT: begin
            res_light_nxt = 1'b1;
            res_err_nxt   = 1'b0;
            state_nxt     = ST_EMIT;
          end
          default: begin
            state_nxt = ST_RDA;
          end
        endcase
      end
      ST_RDA: begin
        opa_nxt   = opnd(ins.a, mem_rdata, w_eff, w_cmp);
        mem_raddr = ins.b;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        state_nxt = ST_ISSUE;
        pc_nxt    = pc_r + 7'd1;
        unique case (ins.op)
          OP_MAC, OP_SQ: begin
            prod_nxt  = mul_res;
            pc_nxt    = pc_r;
            state_nxt = ST_ACC;
          end
          OP_SUN: begin
            mem_we    = 1'b1;
            mem_wdata = sun_axis;
            if ((sun_p >= thr_r) || (sun_m >= thr_r)) begin
              lit_nxt = 1'b1;
            end
          end
          OP_NDIV, OP_ODIV: begin
            if ((ins.op == OP_NDIV) && (root_r == '0)) begin
              // zero-length vector normalizes to zero
              mem_we    = 1'b1;
              mem_wdata = '0;
            end else begin
              pc_nxt    = pc_r;
              dneg_nxt  = opa_r[31];
              drem_nxt  = '0;
              dcnt_nxt  = '0;
              state_nxt = ST_DIV;
              if (ins.op == OP_NDIV) begin
                dq_nxt  = {16'd0, opa_mag, 16'd0};
                dvs_nxt = {1'b0, root_r};
              end else begin
                dq_nxt  = {2'b00, opa_mag, 30'd0};
                dvs_nxt = {root_r, 1'b0};
              end
            end
          end
          OP_BR: begin
            if ($signed(opa_r) <= 32'sd0) begin
              pc_nxt = ins.tgt;
            end
          end
          OP_ARG: begin
            if ($signed(opa_r) <= 32'sd0) begin
              res_light_nxt = 1'b1;
              res_err_nxt   = 1'b1;
              res_q_nxt     = IDENT;
              state_nxt     = ST_EMIT;
            end else begin
              acc_nxt = {16'd0, opa_r, 16'd0};
            end
          end
          default: begin
            pc_nxt = pc_r + 7'd1;
          end
        endcase
      end
      ST_ACC: begin
        acc_nxt = acc_sum;
        if (ins.wr) begin
          mem_we    = 1'b1;
          mem_wdata = sat32(acc_sum);
        end
        pc_nxt    = pc_r + 7'd1;
        state_nxt = ST_ISSUE;
      end
      ST_SQRT: begin
        root_nxt = root_step;
        srem_nxt = srem_step;
        rad_nxt  = {rad_r[61:0], 2'b00};
        scnt_nxt = scnt_r + 5'd1;
        if (scnt_r == 5'd31) begin
          if (ins.wr) begin
            mem_we    = 1'b1;
            mem_wdata = root_step[31] ? SAT_MAX : root_step;
          end
          pc_nxt    = pc_r + 7'd1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_DIV: begin
        dq_nxt   = dq_step;
        drem_nxt = drem_step;
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd63) begin
          if (ins.op == OP_NDIV) begin
            mem_we    = 1'b1;
            mem_wdata = dq_signed[31:0];
          end else begin
            res_q_nxt[ins.d[1:0]] = div_sat;
          end
          pc_nxt    = pc_r + 7'd1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_light_nxt = res_light_r;
          out_err_nxt   = res_err_r;
          out_q_nxt     = res_q_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      lit_r       <= 1'b0;
      thr_r       <= THR_RESET;
      mw_r        <= MW_RESET;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      lit_r       <= lit_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_DARK_THR: thr_r <= cfg_wdata[15:0];
          CFG_MAG_W:    mw_r  <= cfg_wdata;
          default:      thr_r <= thr_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    opa_r       <= opa_nxt;
    root_r      <= root_nxt;
    rad_r       <= rad_nxt;
    srem_r      <= srem_nxt;
    scnt_r      <= scnt_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    dvs_r       <= dvs_nxt;
    dcnt_r      <= dcnt_nxt;
    dneg_r      <= dneg_nxt;
    res_light_r <= res_light_nxt;
    res_err_r   <= res_err_nxt;
    res_q_r     <= res_q_nxt;
    out_light_r <= out_light_nxt;
    out_err_r   <= out_err_nxt;
    out_q_r     <= out_q_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_q_r;
  assign out_tuser  = {out_err_r, out_light_r};

endmodule
